// ----- rtl/sorted_stream_group_count_top_assert.svh -----
// assertion macros for the sorted stream group count block
`ifndef SORTED_STREAM_GROUP_COUNT_TOP_ASSERT_SVH
`define SORTED_STREAM_GROUP_COUNT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sgc_pkg.sv -----
// shared types and constants for the sorted stream group count block
`default_nettype none
package sgc_pkg;

  localparam int MAX_KEYS          = 4;
  localparam int COLUMN_WIDTH_DEF  = 32;
  localparam int COUNT_W           = 32;
  localparam int GC_W              = 3;
  localparam int OFFSET_W          = 3;
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLS        = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_OFFSET_MODE = 1'd1;

  localparam logic [GC_W-1:0] KEY_COLS_RST = 3'd1;

  typedef struct packed {
    logic            use_offset;
    logic [GC_W-1:0] ncols;
  } sgc_mode_t;

endpackage
`default_nettype wire

// ----- rtl/sgc_lane.sv -----
// one key column lane: held column, compare and masked output
`default_nettype none
module sgc_lane #(
  parameter int COLUMN_WIDTH = sgc_pkg::COLUMN_WIDTH_DEF,
  parameter int LANE         = 0
) (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic [COLUMN_WIDTH-1:0] key,
  input  wire logic [sgc_pkg::GC_W-1:0] ncols,
  output logic                         mismatch,
  output logic [COLUMN_WIDTH-1:0]      group_key
);
  import sgc_pkg::*;

  localparam logic [GC_W-1:0] LANE_IDX = GC_W'(LANE);

  logic [COLUMN_WIDTH-1:0] held_key;
  logic                    active;

  always_ff @(posedge clk) begin
    if (load) begin
      held_key <= key;
    end
  end

  assign active    = LANE_IDX < ncols;
  assign mismatch  = active && (key != held_key);
  assign group_key = active ? held_key : '0;

endmodule
`default_nettype wire

// ----- rtl/sgc_merge.sv -----
// merges lane compare results or the offset code into a group-change flag
`default_nettype none
module sgc_merge (
  input  wire sgc_pkg::sgc_mode_t                mode,
  input  wire logic [sgc_pkg::OFFSET_W-1:0]      diff_offset,
  input  wire logic [sgc_pkg::MAX_KEYS-1:0]      mismatch,
  output logic                                   new_group
);
  import sgc_pkg::*;

  always_comb begin
    if (mode.use_offset) begin
      new_group = diff_offset < mode.ncols;
    end else begin
      new_group = |mismatch;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_stream_group_count_top.sv -----
// top level of the sorted stream group count block
//
//   channel  handshake             payload
//   in       in_valid / in_ready   action, key_0..key_3, diff_offset
//   out      out_valid / out_ready group_key_0..group_key_3, group_count
//   cfg      cfg_wr_en             cfg_index, cfg_data
//
// one row per cycle while in_ready is high; key lanes compare and the count
// updates in the cycle of the transfer, the finished group is registered
// for out; an output register plus one skid entry decouple out from in;
// in_ready drops only while the skid entry is full
// rst is synchronous: key_cols=1, key compare mode, no open group
`default_nettype none
module sorted_stream_group_count_top #(
  parameter int COLUMN_WIDTH = sgc_pkg::COLUMN_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [sgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic [COLUMN_WIDTH-1:0]        key_0,
  input  wire logic [COLUMN_WIDTH-1:0]        key_1,
  input  wire logic [COLUMN_WIDTH-1:0]        key_2,
  input  wire logic [COLUMN_WIDTH-1:0]        key_3,
  input  wire logic [sgc_pkg::OFFSET_W-1:0]   diff_offset,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [COLUMN_WIDTH-1:0]             group_key_0,
  output logic [COLUMN_WIDTH-1:0]             group_key_1,
  output logic [COLUMN_WIDTH-1:0]             group_key_2,
  output logic [COLUMN_WIDTH-1:0]             group_key_3,
  output logic [sgc_pkg::COUNT_W-1:0]         group_count
);
  import sgc_pkg::*;

  `include "sorted_stream_group_count_top_assert.svh"

  localparam int RES_W = MAX_KEYS * COLUMN_WIDTH + COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [GC_W-1:0]          key_cols;
  logic                     use_offset_mode;
  sgc_mode_t                mode;

  logic                     have_group;
  logic [COUNT_W-1:0]       row_count;

  logic [COLUMN_WIDTH-1:0]  key_arr [MAX_KEYS];
  logic [COLUMN_WIDTH-1:0]  gkey_arr [MAX_KEYS];
  logic [MAX_KEYS-1:0]      mismatch;
  logic                     new_group;
  logic                     in_fire;
  logic                     load;
  logic                     emit;
  logic [RES_W-1:0]         res_data;

  logic                     skid_valid;
  logic [RES_W-1:0]         out_data;
  logic [RES_W-1:0]         skid_data;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      key_cols        <= KEY_COLS_RST;
      use_offset_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_COLS:        key_cols        <= cfg_data;
        REG_USE_OFFSET_MODE: use_offset_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign mode.use_offset = use_offset_mode;
  assign mode.ncols      = (key_cols > GC_W'(MAX_KEYS)) ? GC_W'(MAX_KEYS)
                                                        : key_cols;

  assign key_arr[0] = key_0;
  assign key_arr[1] = key_1;
  assign key_arr[2] = key_2;
  assign key_arr[3] = key_3;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign load     = in_fire && !action && (!have_group || new_group);
  assign emit     = in_fire && have_group && (action || new_group);

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_lane
    sgc_lane #(
      .COLUMN_WIDTH(COLUMN_WIDTH),
      .LANE        (i)
    ) u_lane (
      .clk      (clk),
      .load     (load),
      .key      (key_arr[i]),
      .ncols    (mode.ncols),
      .mismatch (mismatch[i]),
      .group_key(gkey_arr[i])
    );
  end

  sgc_merge u_merge (
    .mode       (mode),
    .diff_offset(diff_offset),
    .mismatch   (mismatch),
    .new_group  (new_group)
  );

  always_comb begin
    res_data[COUNT_W-1:0] = row_count;
    for (int i = 0; i < MAX_KEYS; i++) begin
      res_data[COUNT_W + i*COLUMN_WIDTH +: COLUMN_WIDTH] = gkey_arr[i];
    end
  end

  // open group state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_group <= 1'b0;
      row_count  <= '0;
    end else if (in_fire) begin
      if (action) begin
        have_group <= 1'b0;
        row_count  <= '0;
      end else if (!have_group || new_group) begin
        have_group <= 1'b1;
        row_count  <= COUNT_W'(1);
      end else if (row_count != COUNT_MAX) begin
        row_count  <= row_count + COUNT_W'(1);
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (emit) begin
      if (!out_valid || out_ready) begin
        out_data <= res_data;
      end else begin
        skid_data <= res_data;
      end
    end
  end

  assign group_count = out_data[COUNT_W-1:0];
  assign group_key_0 = out_data[COUNT_W + 0*COLUMN_WIDTH +: COLUMN_WIDTH];
  assign group_key_1 = out_data[COUNT_W + 1*COLUMN_WIDTH +: COLUMN_WIDTH];
  assign group_key_2 = out_data[COUNT_W + 2*COLUMN_WIDTH +: COLUMN_WIDTH];
  assign group_key_3 = out_data[COUNT_W + 3*COLUMN_WIDTH +: COLUMN_WIDTH];

  `SGC_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid full with out empty")
  `SGC_ASSERT_IMP(a_open_count, have_group, row_count != '0, "open group with zero count")
  `SGC_ASSERT_NEXT(a_eos_closes, in_fire && action, !have_group && row_count == '0,
                   "end of stream left a group open")
  `SGC_ASSERT_NEXT(a_row_opens, in_fire && !action, have_group, "row transfer left no group")
  `SGC_ASSERT_NEXT(a_emit_shows, emit, out_valid, "finished group not presented")

endmodule
`default_nettype wire
